// ===== rtl/core/mcba_pkg.sv =====
// shared constants and types for the multichannel boxcar average
`timescale 1ns / 1ps

package mcba_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam int unsigned MAX_WINDOW_DEF   = 256;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned WIN_W      = 9;
  localparam int unsigned CNT_CFG_W  = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  // register reset values
  localparam logic [WIN_W-1:0]     WINDOW_LENGTH_RST = 9'd8;
  localparam logic [CNT_CFG_W-1:0] CHANNEL_COUNT_RST = 4'd3;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mcba_div_stat_t;

endpackage

// ===== rtl/core/mcba_div.sv =====
// bit-serial signed by unsigned divider, truncating toward zero
`timescale 1ns / 1ps

module mcba_div #(
  parameter int unsigned SUM_W       = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [SUM_W-1:0]     dividend_i,
  input  logic [mcba_pkg::WIN_W-1:0]  divisor_i,
  output logic signed [SAMPLE_BITS-1:0] quotient_o,
  output mcba_pkg::mcba_div_stat_t    stat_o
);
  import mcba_pkg::*;

  localparam int unsigned CntW = $clog2(SUM_W);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [SUM_W-1:0]    quo_q;
  logic [WIN_W-1:0]    rem_q;
  logic [WIN_W-1:0]    div_q;
  logic                neg_q;

  logic [SUM_W-1:0]    mag;
  logic [WIN_W:0]      rem_shift;
  logic [WIN_W+1:0]    trial;
  logic                ge;
  logic [WIN_W-1:0]    rem_d;
  logic [SAMPLE_BITS-1:0] q_mag;

  // magnitude of the dividend
  assign mag = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // one restoring step per cycle
  assign rem_shift = {rem_q, quo_q[SUM_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, div_q};
  assign ge        = ~trial[WIN_W+1];
  assign rem_d     = ge ? trial[WIN_W-1:0] : rem_shift[WIN_W-1:0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // restore the sign
  assign q_mag       = quo_q[SAMPLE_BITS-1:0];
  assign quotient_o  = $signed(neg_q ? (~q_mag + 1'b1) : q_mag);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`ifndef SYNTHESIS
  // busy and done exclude each other
  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("divider busy and done together");

  // a start always begins an iteration run
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q) else $error("divider did not start");

  // the last step raises done
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && (cnt_q == CntW'(SUM_W - 1)) |=> done_q)
    else $error("divider did not finish");
`endif

endmodule

// ===== rtl/core/multichannel_boxcar_average.sv =====
// Multichannel boxcar moving average, top level.
// Samples of up to MAX_CHANNELS interleaved channels enter on the sample
// channel (in_valid_i / in_ready_o), one per transaction, in channel order;
// the block counts channels itself. Each transaction yields one result on
// the output channel (out_valid_o / out_ready_i): the channel's window sum
// divided by window_length, truncated toward zero, with its channel number
// and a last-of-frame flag.
// Per item, in order: acceptance and store read, sum update and store
// write, the bit-serial divider, and the load of the output register.
// The next item is taken as soon as the result sits in the output register,
// so a stalled receiver holds up the input only when a second result is done.
// Reset and every configuration write clear the sums, the write position
// and the channel counter at once and start a clearing pass over all
// 2**(clog2(MAX_CHANNELS)+clog2(MAX_WINDOW)) store entries (2048 at the
// default sizing), one entry per cycle; no sample is taken meanwhile.
// Configuration writes are taken at any time, but belong in idle periods.
`timescale 1ns / 1ps

module multichannel_boxcar_average #(
  parameter int unsigned MAX_CHANNELS = mcba_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned MAX_WINDOW   = mcba_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS  = mcba_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [mcba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcba_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // samples
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  // averages
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     average_o,
  output logic [ChW-1:0]                    channel_o,
  output logic                              frame_last_o
);
  import mcba_pkg::*;

  localparam int unsigned PosW  = $clog2(MAX_WINDOW);
  localparam int unsigned AddrW = ChW + PosW;
  localparam int unsigned SumW  = SAMPLE_BITS + PosW;
  localparam int unsigned CntW  = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_DIV
  } state_e;

  state_e                 state_q;
  logic [WIN_W-1:0]       window_length_q;
  logic [CNT_CFG_W-1:0]   channel_count_q;
  logic [AddrW-1:0]       clr_addr_q;
  logic [PosW-1:0]        pos_q;
  logic [ChW-1:0]         chan_q;
  logic signed [SumW-1:0] sums_q [MAX_CHANNELS];
  logic                   out_valid_q;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [AddrW-1:0]       addr_q;
  logic [ChW-1:0]         ch_q;
  logic                   last_q;
  logic signed [SAMPLE_BITS-1:0] average_q;
  logic [ChW-1:0]         channel_q;
  logic                   frame_last_q;

  logic signed [SAMPLE_BITS-1:0] store_q [2**AddrW];
  logic signed [SAMPLE_BITS-1:0] rdata_q;

  logic [WIN_W-1:0]       len_eff;
  logic [CntW-1:0]        chans_eff;
  logic [ChW-1:0]         ch_cur;
  logic [PosW-1:0]        pos_base;
  logic [PosW-1:0]        pos_nxt;
  logic                   last_cur;
  logic [ChW-1:0]         chan_nxt;
  logic                   in_acc;
  logic                   out_load;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic signed [SAMPLE_BITS-1:0] mem_wdata;
  logic signed [SumW-1:0] sum_new;
  logic                   div_start;
  logic signed [SAMPLE_BITS-1:0] div_quot;
  mcba_div_stat_t         div_stat;

  // effective register values
  always_comb begin
    if (window_length_q == '0) begin
      len_eff = WIN_W'(1);
    end else if (int'(window_length_q) > int'(MAX_WINDOW)) begin
      len_eff = WIN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length_q;
    end
    if (channel_count_q == '0) begin
      chans_eff = CntW'(1);
    end else if (int'(channel_count_q) > int'(MAX_CHANNELS)) begin
      chans_eff = CntW'(MAX_CHANNELS);
    end else begin
      chans_eff = CntW'(channel_count_q);
    end
  end

  // channel and circular position of the incoming sample
  always_comb begin
    ch_cur   = (int'(chan_q) >= int'(chans_eff)) ? '0 : chan_q;
    pos_base = (int'(pos_q) >= int'(len_eff)) ? '0 : pos_q;
    pos_nxt  = pos_base;
    if (ch_cur == '0) begin
      pos_nxt = (int'(pos_base) + 1 >= int'(len_eff)) ? '0 : pos_base + 1'b1;
    end
    last_cur = (int'(ch_cur) + 1 >= int'(chans_eff));
    chan_nxt = last_cur ? '0 : ch_cur + 1'b1;
  end

  assign in_ready_o = (state_q == ST_IDLE) && !cfg_we_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DIV) && div_stat.done &&
                      (!out_valid_q || out_ready_i);
  assign div_start  = (state_q == ST_UPD);

  // running sum update: old sample leaves, new one enters
  assign sum_new = sums_q[ch_q] - SumW'(rdata_q) + SumW'(sample_q);

  // store write: clearing pass or sample write-back
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : sample_q;

  // sample store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_q <= store_q[{ch_cur, pos_nxt}];
    end
  end

  // sequencer, registers, sums and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      window_length_q <= WINDOW_LENGTH_RST;
      channel_count_q <= CHANNEL_COUNT_RST;
      clr_addr_q      <= '0;
      pos_q           <= '0;
      chan_q          <= '0;
      out_valid_q     <= 1'b0;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_LENGTH: window_length_q <= cfg_data_i[WIN_W-1:0];
          CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CNT_CFG_W-1:0];
          default: ;
        endcase
        state_q    <= ST_CLEAR;
        clr_addr_q <= '0;
        pos_q      <= '0;
        chan_q     <= '0;
        for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
          sums_q[i] <= '0;
        end
      end else begin
        case (state_q)
          ST_CLEAR: begin
            clr_addr_q <= clr_addr_q + 1'b1;
            if (clr_addr_q == '1) begin
              state_q <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_acc) begin
              pos_q   <= pos_nxt;
              chan_q  <= chan_nxt;
              state_q <= ST_UPD;
            end
          end
          ST_UPD: begin
            sums_q[ch_q] <= sum_new;
            state_q      <= ST_DIV;
          end
          ST_DIV: begin
            if (out_load) begin
              state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_CLEAR;
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
      addr_q   <= {ch_cur, pos_nxt};
      ch_q     <= ch_cur;
      last_q   <= last_cur;
    end
    if (out_load) begin
      average_q    <= div_quot;
      channel_q    <= ch_q;
      frame_last_q <= last_q;
    end
  end

  mcba_div #(
    .SUM_W       (SumW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (len_eff),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  assign out_valid_o  = out_valid_q;
  assign average_o    = average_q;
  assign channel_o    = channel_q;
  assign frame_last_o = frame_last_q;

`ifndef SYNTHESIS
  // a configuration write stops sample intake for the clearing pass
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o) else $error("sample taken right after config write");

  // the divider is never restarted while it iterates
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

  // an accepted transaction goes to the sum update next
  a_accept_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_we_i |=> state_q == ST_UPD) else $error("sum update skipped");

  // channel counter stays within the configured channel count
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(chan_q) < int'(chans_eff)) else $error("channel counter out of range");
`endif

endmodule
